### design/keyed_hit_counter_table_assert.svh
// Assertion macros for the hit counter table checker.
// Each expects clk and arst_n in the scope where it is used.
`ifndef KEYED_HIT_COUNTER_TABLE_ASSERT_SVH
`define KEYED_HIT_COUNTER_TABLE_ASSERT_SVH

// same-cycle implication
`define KHC_ASSERT_IMP(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("khc assertion failed");

// next-cycle implication
`define KHC_ASSERT_NXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("khc assertion failed");

`endif

### design/khc_pkg.sv
package khc_pkg;

	localparam int SENSOR_W          = 16;
	localparam int CNT_W             = 32;
	localparam int TABLE_ENTRIES_DEF = 64;
	localparam int ID_BITS_DEF       = 16;

	// broadcast to every cell of the chain
	typedef struct packed {
		logic insert;  // new key goes into its sorted slot
		logic bump;    // matching cell counts up
		logic shift;   // dump: every cell takes its right neighbor
	} cell_ctrl_t;

endpackage

### design/khc_cell.sv
module khc_cell #(
	parameter int ID_W = khc_pkg::ID_BITS_DEF
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  khc_pkg::cell_ctrl_t       ctrl,
	input  logic [ID_W-1:0]           key,
	input  logic                      left_valid,
	input  logic [ID_W-1:0]           left_id,
	input  logic [khc_pkg::CNT_W-1:0] left_cnt,
	input  logic                      left_gt,
	input  logic                      right_valid,
	input  logic [ID_W-1:0]           right_id,
	input  logic [khc_pkg::CNT_W-1:0] right_cnt,
	output logic                      valid,
	output logic [ID_W-1:0]           id,
	output logic [khc_pkg::CNT_W-1:0] cnt,
	output logic                      gt,
	output logic                      match
);

	logic                      valid_q;
	logic [ID_W-1:0]           id_q;
	logic [khc_pkg::CNT_W-1:0] cnt_q;

	assign valid = valid_q;
	assign id    = id_q;
	assign cnt   = cnt_q;
	assign match = valid_q && (id_q == key);
	// an empty cell sorts above every key; the chain is kept packed from cell 0
	assign gt    = !valid_q || (id_q > key);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (ctrl.shift) begin
			valid_q <= right_valid;
		end else if (ctrl.insert && gt) begin
			valid_q <= left_gt ? left_valid : 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (ctrl.shift) begin
			id_q  <= right_id;
			cnt_q <= right_cnt;
		end else if (ctrl.insert && gt) begin
			// left neighbor also above key: make room; else this is the slot
			if (left_gt) begin
				id_q  <= left_id;
				cnt_q <= left_cnt;
			end else begin
				id_q  <= key;
				cnt_q <= khc_pkg::CNT_W'(1);
			end
		end else if (ctrl.bump && match && (cnt_q != '1)) begin
			cnt_q <= cnt_q + khc_pkg::CNT_W'(1);
		end
	end

endmodule

### design/keyed_hit_counter_table.sv
// Hit counter table keyed by sensor ID, kept sorted by ID in a chain of cells.
// Input s_axis: tuser[0] = mode (0 hit, 1 dump), tdata[15:0] = sensor_id.
// On a hit all cells compare the key at once; the matching cell
// counts up (saturating), or on a miss the new entry is inserted in order while
// the cells above it move one place right. With the table full the hit is
// dropped and the drop counter rises (saturating).
// A dump shifts the chain left one cell per output word, so records leave in
// ascending ID order, one per cycle while m_axis_tready is high; the first
// record is loaded after the dump accept sets dumping_q. N entries give N
// records, an empty table one record with entry_valid 0; tlast marks the end.
// s_axis_tready is low from dump accept until the last record is in the output
// register; a stalled receiver holds the chain. The dump empties the table and
// clears the drop counter. Reset empties the table at once (no clearing pass).
module keyed_hit_counter_table #(
	parameter int TABLE_ENTRIES = khc_pkg::TABLE_ENTRIES_DEF,
	parameter int ID_BITS       = khc_pkg::ID_BITS_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [15:0] s_axis_tdata,   // [15:0] sensor_id
	input  logic [0:0]  s_axis_tuser,   // [0] mode
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [79:0] m_axis_tdata,   // [15:0] sensor_id_res, [47:16] hit_count,
	                                    // [79:48] dropped_hits
	output logic [0:0]  m_axis_tuser,   // [0] entry_valid
	output logic        m_axis_tlast
);

	localparam int IdW = (ID_BITS < khc_pkg::SENSOR_W) ? ID_BITS : khc_pkg::SENSOR_W;
	localparam int CntW = khc_pkg::CNT_W;

	logic                cv     [TABLE_ENTRIES];
	logic [IdW-1:0]      cid    [TABLE_ENTRIES];
	logic [CntW-1:0]     ccnt   [TABLE_ENTRIES];
	logic                cgt    [TABLE_ENTRIES];
	logic [TABLE_ENTRIES-1:0] cmatch;

	logic                in_acc, hit_acc, dump_acc, any_match, full, load, rec_last;
	logic [IdW-1:0]      key;
	khc_pkg::cell_ctrl_t ctrl;

	logic                dumping_q;
	logic [CntW-1:0]     dropped_q, dump_drop_q;
	logic                out_valid_q, out_ev_q, out_last_q;
	logic [15:0]         out_id_q;
	logic [CntW-1:0]     out_cnt_q, out_drop_q;

	assign s_axis_tready = !dumping_q;
	assign in_acc    = s_axis_tvalid && s_axis_tready;
	assign hit_acc   = in_acc && !s_axis_tuser[0];
	assign dump_acc  = in_acc && s_axis_tuser[0];
	assign key       = s_axis_tdata[IdW-1:0];
	assign any_match = |cmatch;
	assign full      = cv[TABLE_ENTRIES-1];
	assign load      = dumping_q && (!out_valid_q || m_axis_tready);
	assign rec_last  = !cv[0] || !cv[1];

	assign ctrl.insert = hit_acc && !any_match && !full;
	assign ctrl.bump   = hit_acc;
	assign ctrl.shift  = load;

	for (genvar i = 0; i < TABLE_ENTRIES; i++) begin : g_cell
		logic            lv, lgt, rv;
		logic [IdW-1:0]  lid, rid;
		logic [CntW-1:0] lcnt, rcnt;

		if (i == 0) begin : g_first
			assign lv   = 1'b0;
			assign lid  = '0;
			assign lcnt = '0;
			assign lgt  = 1'b0;
		end else begin : g_inner_l
			assign lv   = cv[i-1];
			assign lid  = cid[i-1];
			assign lcnt = ccnt[i-1];
			assign lgt  = cgt[i-1];
		end

		if (i == TABLE_ENTRIES - 1) begin : g_last
			assign rv   = 1'b0;
			assign rid  = '0;
			assign rcnt = '0;
		end else begin : g_inner_r
			assign rv   = cv[i+1];
			assign rid  = cid[i+1];
			assign rcnt = ccnt[i+1];
		end

		khc_cell #(.ID_W(IdW)) u_cell (
			.clk        (clk),
			.arst_n     (arst_n),
			.ctrl       (ctrl),
			.key        (key),
			.left_valid (lv),
			.left_id    (lid),
			.left_cnt   (lcnt),
			.left_gt    (lgt),
			.right_valid(rv),
			.right_id   (rid),
			.right_cnt  (rcnt),
			.valid      (cv[i]),
			.id         (cid[i]),
			.cnt        (ccnt[i]),
			.gt         (cgt[i]),
			.match      (cmatch[i])
		);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dumping_q <= 1'b0;
			dropped_q <= '0;
		end else begin
			if (dump_acc) begin
				dumping_q <= 1'b1;
				dropped_q <= '0;
			end else if (load && rec_last) begin
				dumping_q <= 1'b0;
			end
			if (hit_acc && !any_match && full && (dropped_q != '1)) begin
				dropped_q <= dropped_q + CntW'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (dump_acc) begin
			dump_drop_q <= dropped_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (load) begin
			out_valid_q <= 1'b1;
		end else if (m_axis_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			out_id_q   <= cv[0] ? 16'(cid[0]) : 16'd0;
			out_cnt_q  <= cv[0] ? ccnt[0] : '0;
			out_ev_q   <= cv[0];
			out_last_q <= rec_last;
			out_drop_q <= dump_drop_q;
		end
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = {out_drop_q, out_cnt_q, out_id_q};
	assign m_axis_tuser  = out_ev_q;
	assign m_axis_tlast  = out_last_q;

endmodule

### design/khc_checker.sv
`include "keyed_hit_counter_table_assert.svh"

module khc_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        s_axis_tvalid,
	input logic        s_axis_tready,
	input logic [15:0] s_axis_tdata,
	input logic [0:0]  s_axis_tuser,
	input logic        m_axis_tvalid,
	input logic        m_axis_tready,
	input logic [79:0] m_axis_tdata,
	input logic [0:0]  m_axis_tuser,
	input logic        m_axis_tlast
);

	// a stalled output word holds
	`KHC_ASSERT_NXT(a_out_hold, m_axis_tvalid && !m_axis_tready,
		m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tlast))

	// empty-table record is the only one of its dump
	`KHC_ASSERT_IMP(a_empty_rec, m_axis_tvalid && !m_axis_tuser[0],
		m_axis_tlast && (m_axis_tdata[47:0] == 48'd0))

	// an entry always carries at least one hit
	`KHC_ASSERT_IMP(a_count_nz, m_axis_tvalid && m_axis_tuser[0],
		m_axis_tdata[47:16] != 32'd0)

	// no new word is taken in mid-dump
	`KHC_ASSERT_IMP(a_dump_block, m_axis_tvalid && !m_axis_tlast, !s_axis_tready)

	// records of one dump rise strictly in ID
	`KHC_ASSERT_IMP(a_sorted,
		m_axis_tvalid && $past(m_axis_tvalid && m_axis_tready && !m_axis_tlast),
		m_axis_tdata[15:0] > $past(m_axis_tdata[15:0]))

	logic unused_in;
	assign unused_in = s_axis_tvalid ^ (^s_axis_tdata) ^ s_axis_tuser[0];

endmodule

bind keyed_hit_counter_table khc_checker u_khc_checker (
	.clk          (clk),
	.arst_n       (arst_n),
	.s_axis_tvalid(s_axis_tvalid),
	.s_axis_tready(s_axis_tready),
	.s_axis_tdata (s_axis_tdata),
	.s_axis_tuser (s_axis_tuser),
	.m_axis_tvalid(m_axis_tvalid),
	.m_axis_tready(m_axis_tready),
	.m_axis_tdata (m_axis_tdata),
	.m_axis_tuser (m_axis_tuser),
	.m_axis_tlast (m_axis_tlast)
);
